/* hw/rtl/pcm_decode_downmix_mono_assert.svh */
// ---------------------------------------------------------------------------
// assertion macros for the pcm decode and downmix block
// all macros sample on clk and are disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef PCM_DECODE_DOWNMIX_MONO_ASSERT_SVH
`define PCM_DECODE_DOWNMIX_MONO_ASSERT_SVH

// same-cycle implication
`define PDM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pdm_pkg.sv */
// ---------------------------------------------------------------------------
// pdm_pkg
// shared constants and controller/datapath interface types
// ---------------------------------------------------------------------------
package pdm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_W     = 32;
  localparam int SUM_W        = SAMPLE_W + $clog2(MAX_CHANNELS);
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
  localparam int DIV_STEPS    = SUM_W;
  localparam int STEP_W       = $clog2(DIV_STEPS);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_FORMAT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  // sample_size codes
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_24 = 2'd2;
  localparam logic [1:0] SIZE_32 = 2'd3;

  // float32 exponent landmarks
  localparam logic [7:0] EXP_ZERO = 8'd0;
  localparam logic [7:0] EXP_SPEC = 8'd255;
  localparam logic [7:0] EXP_SAT  = 8'd127;
  localparam logic [7:0] EXP_UNIT = 8'd119;

  typedef struct packed {
    logic load_sample;
    logic accumulate;
    logic div_step;
    logic load_out;
  } pdm_cmd_t;

  typedef struct packed {
    logic frame_end;
  } pdm_sts_t;

endpackage

/* hw/rtl/pdm_dp.sv */
// ---------------------------------------------------------------------------
// pdm_dp
// sample conversion to q1.31, frame accumulator and bit-serial divider
// ---------------------------------------------------------------------------
module pdm_dp
  import pdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [SAMPLE_W-1:0]   in_tdata,
  input  pdm_cmd_t              cmd,
  output pdm_sts_t              sts,
  output logic [SAMPLE_W-1:0]   out_tdata
);

  logic [1:0]             sample_size_r;
  logic                   float_format_r;
  logic [CFG_DATA_W-1:0]  channel_count_r;

  logic [SAMPLE_W-1:0]    q_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]       idx_r;
  logic [SUM_W-1:0]       quo_r;
  logic [CNT_W-1:0]       rem_r;
  logic [CNT_W-1:0]       dvs_r;
  logic                   neg_r;
  logic [SAMPLE_W-1:0]    out_r;

  logic [SAMPLE_W-1:0]    q_int;
  logic [SAMPLE_W-1:0]    q_flt;
  logic [SAMPLE_W-1:0]    mag;
  logic [7:0]             ex;
  logic [7:0]             sh;
  logic [SAMPLE_W-1:0]    sig;
  logic [CNT_W-1:0]       cnt_eff;
  logic signed [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0]       sum_abs;
  logic [CNT_W-1:0]       idx_new;
  logic                   frame_end;
  logic [CNT_W:0]         rem_sh;
  logic                   rem_ge;
  logic [CNT_W:0]         rem_sub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_size_r   <= SIZE_16;
      float_format_r  <= 1'b0;
      channel_count_r <= CFG_DATA_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_SIZE:   sample_size_r   <= cfg_wdata[1:0];
        CFG_FLOAT_FORMAT:  float_format_r  <= cfg_wdata[0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sample_size_r)
      SIZE_8:  q_int = {in_tdata[7:0] ^ 8'h80, 24'b0};
      SIZE_16: q_int = {in_tdata[15:0], 16'b0};
      SIZE_24: q_int = {in_tdata[23:0], 8'b0};
      default: q_int = in_tdata;
    endcase
  end

  // float32 to q1.31, truncating, saturating at one
  always_comb begin
    ex  = in_tdata[30:23];
    sig = {8'b0, 1'b1, in_tdata[22:0]};
    sh  = EXP_UNIT - ex;
    mag = '0;
    if (ex >= EXP_UNIT) begin
      mag = sig << 3'(ex - EXP_UNIT);
    end else if (sh < 8'd24) begin
      mag = sig >> sh[4:0];
    end
    if (ex == EXP_SPEC || ex == EXP_ZERO) begin
      q_flt = '0;
    end else if (ex >= EXP_SAT) begin
      q_flt = in_tdata[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      q_flt = in_tdata[31] ? (32'd0 - mag) : mag;
    end
  end

  always_comb begin
    if (channel_count_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (32'(channel_count_r) > MAX_CHANNELS) begin
      cnt_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      cnt_eff = CNT_W'(channel_count_r);
    end
  end

  assign sum_new   = sum_r + SUM_W'(signed'(q_r));
  assign sum_abs   = sum_new[SUM_W-1] ? (SUM_W'(0) - sum_new) : sum_new;
  assign idx_new   = idx_r + CNT_W'(1);
  assign frame_end = idx_new >= cnt_eff;
  assign sts.frame_end = frame_end;

  // restoring division, one quotient bit a step
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      idx_r <= '0;
    end else if (cmd.accumulate) begin
      if (frame_end) begin
        sum_r <= '0;
        idx_r <= '0;
      end else begin
        sum_r <= sum_new;
        idx_r <= idx_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      q_r <= float_format_r ? q_flt : q_int;
    end
    if (cmd.accumulate && frame_end) begin
      quo_r <= sum_abs;
      rem_r <= '0;
      dvs_r <= cnt_eff;
      neg_r <= sum_new[SUM_W-1];
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[SUM_W-2:0], rem_ge};
      rem_r <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
    if (cmd.load_out) begin
      out_r <= neg_r ? (SAMPLE_W'(0) - quo_r[SAMPLE_W-1:0]) : quo_r[SAMPLE_W-1:0];
    end
  end

  assign out_tdata = out_r;

endmodule

/* hw/rtl/pdm_ctrl.sv */
// ---------------------------------------------------------------------------
// pdm_ctrl
// sequencer for accept, accumulate, divide and result hand-off
// ---------------------------------------------------------------------------
module pdm_ctrl
  import pdm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  pdm_sts_t sts,
  output pdm_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              last_step;

  assign last_step = step_r == STEP_W'(DIV_STEPS - 1);

  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    cmd             = '0;
    cmd.load_sample = (state_r == S_IDLE) && in_tvalid;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        step_nxt       = '0;
        state_nxt      = sts.frame_end ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (last_step) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        // wait until the previous result has been taken
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

`include "pcm_decode_downmix_mono_assert.svh"

  `PDM_ASSERT_NEXT(a_accept_to_acc, in_tvalid && in_tready, state_r == S_ACC, "transfer not followed by accumulate")
  `PDM_ASSERT_NEXT(a_div_done, state_r == S_DIV && last_step, state_r == S_HOLD, "divider overran its step count")
  `PDM_ASSERT_NEXT(a_result_held, out_valid_r && !out_tready, out_valid_r, "pending result lost")
  `PDM_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_tready, !cmd.load_out, "pending result overwritten")
  `PDM_ASSERT_NOW(a_no_accept_busy, cmd.div_step || cmd.accumulate, !in_tready, "input ready while frame work is in flight")

endmodule

/* hw/rtl/pcm_decode_downmix_mono.sv */
// ---------------------------------------------------------------------------
// pcm_decode_downmix_mono
// pcm / float32 sample decoder with channel-averaging mono downmix
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  in_*      slave      tdata[31:0] sample_word
//  out_*     master     tdata[31:0] mono_sample (signed q1.31)
//  cfg_*     write      index 0 sample_size, 1 float_format, 2 channel_count
//
//  a sample that does not close a frame passes through accept and accumulate
//  the closing sample passes through accept, accumulate, 35 divider steps
//  of the bit-serial restoring divider, and the result register load
//  a waiting result holds back only the next result load, and the input
//  with it, while the next frame's mean is ready
//  synchronous active-low reset; no clearing pass is needed
// ---------------------------------------------------------------------------
module pcm_decode_downmix_mono
  import pdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [31:0] sample_word
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata   // [31:0] mono_sample
);

  pdm_cmd_t cmd;
  pdm_sts_t sts;

  pdm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pdm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule
